// ----- design/bpfa_pkg.sv -----
`timescale 1ns / 1ps

package bpfa_pkg;

  // Widths of the request and result fields
  localparam int MODE_W = 2;
  localparam int IDX_W  = 15;
  localparam int CNT_W  = 16;

  // Map word geometry: one bit per block, 32 blocks per memory word
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int FLIP_W = 6;

  // Block numbers never reach past the 15-bit index space
  localparam int INDEX_SPAN      = 32768;
  localparam int DEF_MAX_BLOCKS  = 32768;
  localparam logic [CNT_W-1:0] MANAGED_RESET = 16'd32768;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd3;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_t;

  // Control from the sequencer to the word unit
  typedef struct packed {
    logic             alloc;
    logic             set_bits;
    logic             lo_cut;
    logic [BIT_W-1:0] lo_bit;
    logic             hi_cut;
    logic [BIT_W-1:0] hi_bit;
  } word_ctl_t;

  // Status back from the word unit
  typedef struct packed {
    logic [WORD_W-1:0] new_word;
    logic [FLIP_W-1:0] flips;
    logic              hit;
    logic [BIT_W-1:0]  hit_bit;
  } word_res_t;

endpackage

// ----- design/bpfa_word_unit.sv -----
`timescale 1ns / 1ps

module bpfa_word_unit import bpfa_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  word_ctl_t         ctl,
  output word_res_t         res
);

  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] win;
  logic [WORD_W-1:0] cand;
  logic [WORD_W-1:0] lowest;
  logic [WORD_W-1:0] flip_bits;
  logic [BIT_W-1:0]  enc;

  // Build the window of blocks inside this word that the request covers
  always_comb begin
    lo_mask = ctl.lo_cut ? ({WORD_W{1'b1}} << ctl.lo_bit) : {WORD_W{1'b1}};
    hi_mask = ctl.hi_cut ? ((WORD_W'(1) << ctl.hi_bit) - WORD_W'(1)) : {WORD_W{1'b1}};
    win     = lo_mask & hi_mask;
  end

  // Pick the lowest free block in the window
  always_comb begin
    cand   = ~word & win;
    lowest = cand & (~cand + WORD_W'(1));
    enc    = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        enc = enc | BIT_W'(i);
      end
    end
  end

  // Flip the bits and count them
  always_comb begin
    if (ctl.alloc) begin
      flip_bits = lowest;
    end else if (ctl.set_bits) begin
      flip_bits = win & ~word;
    end else begin
      flip_bits = win & word;
    end
    res.new_word = word ^ flip_bits;
    res.flips    = FLIP_W'($countones(flip_bits));
    res.hit      = |cand;
    res.hit_bit  = enc;
  end

endmodule

// ----- design/bitmap_page_frame_allocator.sv -----
`timescale 1ns / 1ps

// First-fit page frame allocator over a used map of one bit per block, held
// 32 blocks to a word in a single-port memory, with a count of free blocks.
// After reset a clearing pass marks every block used, one word a cycle (one
// word per 32 blocks of the map, 1024 words at the default); requests wait
// for it, while managed_blocks writes are taken at any time. A request then
// reads each map word it visits, then modifies and writes it back through the
// shared word unit. Allocate visits words from block 0 up to the first free
// block, free visits one word, a range visits each word it spans, and a
// request with nothing to visit goes straight to its result. The result waits
// in an output register while the next request is taken.
module bitmap_page_frame_allocator import bpfa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [IDX_W-1:0]  first_block,
  input  logic [CNT_W-1:0]  range_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              granted,
  output logic [IDX_W-1:0]  block_index,
  output logic [CNT_W-1:0]  changed_count,
  output logic [CNT_W-1:0]  free_count
);

  localparam int LIM_CAP = (MAX_BLOCKS < INDEX_SPAN) ? MAX_BLOCKS : INDEX_SPAN;
  localparam int DEPTH   = (LIM_CAP + WORD_W - 1) / WORD_W;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  logic [CNT_W-1:0]  managed_blocks;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  req_lo;
  logic [CNT_W-1:0]  req_bound;
  logic [CNT_W-1:0]  free_end;
  logic              req_empty;

  logic              op_alloc;
  logic              op_set;
  logic              op_free;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  bound;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_step;
  logic [CNT_W-1:0]  changed;
  logic              hit_seen;
  logic [IDX_W-1:0]  hit_index;
  logic [AW-1:0]     fill_addr;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  word_ctl_t         ctl;
  word_res_t         res;
  logic              accept;
  logic              out_load;
  logic              last_word;

  // Effective limit and the span of a new request
  always_comb begin
    lim      = (managed_blocks > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : managed_blocks;
    free_end = {1'b0, first_block} + CNT_W'(1);
    case (mode)
      MODE_ALLOC: begin
        req_lo    = '0;
        req_bound = lim;
      end
      MODE_FREE: begin
        req_lo    = {1'b0, first_block};
        req_bound = (free_end < lim) ? free_end : lim;
      end
      default: begin
        req_lo    = {1'b0, first_block};
        req_bound = (range_end < lim) ? range_end : lim;
      end
    endcase
    req_empty = (req_lo >= req_bound);
  end

  assign accept    = in_valid && in_ready;
  assign out_load  = !out_valid || out_ready;
  assign pos_step  = pos + CNT_W'(WORD_W);
  assign last_word = (pos_step >= bound);

  // Word unit control for the word at pos
  always_comb begin
    ctl.alloc    = op_alloc;
    ctl.set_bits = op_set;
    ctl.lo_cut   = (pos[CNT_W-1:BIT_W] == lo[CNT_W-1:BIT_W]);
    ctl.lo_bit   = lo[BIT_W-1:0];
    ctl.hi_cut   = (pos[CNT_W-1:BIT_W] == bound[CNT_W-1:BIT_W]);
    ctl.hi_bit   = bound[BIT_W-1:0];
  end

  bpfa_word_unit u_word (
    .word (rd_word),
    .ctl  (ctl),
    .res  (res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (fill_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = req_empty ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_MODIFY;
      end
      ST_MODIFY: begin
        if ((op_alloc && res.hit) || last_word) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pos[AW+BIT_W-1:BIT_W];
    mem_wdata = res.new_word;
    case (state)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = fill_addr;
        mem_wdata = {WORD_W{1'b1}};
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_MODIFY: begin
        mem_we = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Map memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word <= mem[mem_addr];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_FILL;
      fill_addr      <= '0;
      managed_blocks <= MANAGED_RESET;
      free_total     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FILL) begin
        fill_addr <= fill_addr + AW'(1);
      end
      if (cfg_wr_en) begin
        managed_blocks <= cfg_wr_data;
      end
      if (state == ST_MODIFY) begin
        if (op_alloc || op_set) begin
          free_total <= free_total - CNT_W'(res.flips);
        end else begin
          free_total <= free_total + CNT_W'(res.flips);
        end
      end
      if (state == ST_DONE && out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request registers: latch on accept, advance per word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_alloc  <= (mode == MODE_ALLOC);
      op_set    <= (mode == MODE_RESERVE);
      op_free   <= (mode == MODE_FREE);
      lo        <= req_lo;
      bound     <= req_bound;
      pos       <= {req_lo[CNT_W-1:BIT_W], {BIT_W{1'b0}}};
      changed   <= '0;
      hit_seen  <= 1'b0;
      hit_index <= '0;
    end else if (state == ST_MODIFY) begin
      pos     <= pos_step;
      changed <= changed + CNT_W'(res.flips);
      if (op_alloc && res.hit) begin
        hit_seen  <= 1'b1;
        hit_index <= {pos[IDX_W-1:BIT_W], res.hit_bit};
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_load) begin
      granted       <= op_free ? (changed != '0) : hit_seen;
      block_index   <= hit_index;
      changed_count <= changed;
      free_count    <= free_total;
    end
  end

endmodule
